### src/kufj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufj_pkg
// Shared widths, state and select codes, and the controller/datapath
// command and status words for the union-find edge joiner.
// ----------------------------------------------------------------------------
package kufj_pkg;

    localparam int ID_W          = 10;
    localparam int WGT_W         = 31;
    localparam int TOT_W         = 41;
    localparam int CNT_W         = 10;
    localparam int NC_W          = 11;
    localparam int ID_SPAN       = 1 << ID_W;
    localparam int NC_RESET      = 1024;
    localparam int MAX_NODES_DEF = 1024;

    localparam int S_FIELDS_W = 2 * ID_W + WGT_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + TOT_W + CNT_W + 1 + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_COMP_A,
        ST_WALK_B,
        ST_COMP_B,
        ST_LINK
    } state_t;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_DATA,
        RD_START_A,
        RD_START_B
    } rd_sel_t;

    typedef struct packed {
        logic    clr_wr;
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    phase_b;
        logic    root_ld;
        logic    comp_wr;
        logic    link;
    } cmd_t;

    typedef struct packed {
        logic bad_in;
        logic is_root;
        logic comp_end;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

### src/kruskal_union_find_joiner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_union_find_joiner
// After reset the parent table is swept one entry a cycle (DEPTH entries,
// 1024 by default) before the first word is taken.
// An accepted edge walks end_one to its root and compresses that path, does
// the same for end_two, then links the two roots and registers the result;
// an edge with an id at or above the capped node_count goes to the link step.
// One edge is in flight at a time; the next word can be taken while its result
// waits on the output, and a result not yet taken holds the link step.
// ----------------------------------------------------------------------------
module kruskal_union_find_joiner
    import kufj_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [NC_W-1:0]     cfg_wdata,     // node_count
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,       // end_one, end_two, edge_weight
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata        // joined, tree_weight, joined_edges,
                                               // spanning, bad_node
);

    localparam int DEPTH = (MAX_NODES < ID_SPAN) ? MAX_NODES : ID_SPAN;
    localparam int IDX_W = $clog2(DEPTH);

    cmd_t cmd;
    sts_t sts;

    kufj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kufj_dp #(
        .MAX_NODES (MAX_NODES),
        .DEPTH     (DEPTH),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### src/kufj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufj_ctrl
// Sequencer: clearing pass, two root walks with compression, then link and
// result load.
// ----------------------------------------------------------------------------
module kufj_ctrl
    import kufj_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.rd_sel  = RD_DATA;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_INPUT;
                    state_next  = sts.bad_in ? ST_LINK : ST_WALK_A;
                end
            end
            ST_WALK_A:
            begin
                cmd.rd_en = 1'b1;
                if (sts.is_root)
                begin
                    cmd.root_ld = 1'b1;
                    cmd.rd_sel  = RD_START_A;
                    state_next  = ST_COMP_A;
                end
            end
            ST_COMP_A:
            begin
                cmd.comp_wr = 1'b1;
                cmd.rd_en   = 1'b1;
                if (sts.comp_end)
                begin
                    cmd.rd_sel = RD_START_B;
                    state_next = ST_WALK_B;
                end
            end
            ST_WALK_B:
            begin
                cmd.phase_b = 1'b1;
                cmd.rd_en   = 1'b1;
                if (sts.is_root)
                begin
                    cmd.root_ld = 1'b1;
                    cmd.rd_sel  = RD_START_B;
                    state_next  = ST_COMP_B;
                end
            end
            ST_COMP_B:
            begin
                cmd.phase_b = 1'b1;
                cmd.comp_wr = 1'b1;
                if (sts.comp_end)
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_LINK:
            begin
                if (sts.out_free)
                begin
                    cmd.link   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/kufj_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kufj_dp
// Parent table memory, walk and root registers, node count register,
// running totals and the result register.
// ----------------------------------------------------------------------------
module kufj_dp
    import kufj_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int DEPTH     = (MAX_NODES < ID_SPAN) ? MAX_NODES : ID_SPAN,
    parameter int IDX_W     = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [NC_W-1:0]     cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  cmd_t                cmd,
    output sts_t                sts
);

    localparam int NC_MAX = (1 << NC_W) - 1;
    localparam logic [NC_W-1:0] MAX_CAP = NC_W'((MAX_NODES > NC_MAX) ? NC_MAX : MAX_NODES);
    localparam int M_PAD_W = M_DATA_W - M_FIELDS_W;

    logic [IDX_W-1:0] parent_mem [DEPTH];

    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] root_a_reg;
    logic [IDX_W-1:0] root_b_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [WGT_W-1:0] w_reg;
    logic             bad_reg;
    logic [IDX_W-1:0] clr_reg;
    logic [NC_W-1:0]  node_count_reg;
    logic [TOT_W-1:0] weight_total_reg;
    logic [CNT_W-1:0] edge_total_reg;
    logic             out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [ID_W-1:0]  in_a;
    logic [ID_W-1:0]  in_b;
    logic [WGT_W-1:0] in_w;
    logic [NC_W-1:0]  lim;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] root_cur;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             joined;
    logic [TOT_W-1:0] weight_next;
    logic [CNT_W-1:0] edge_next;
    logic             spanning;

    assign in_a = s_tdata[ID_W-1:0];
    assign in_b = s_tdata[2*ID_W-1:ID_W];
    assign in_w = s_tdata[2*ID_W+WGT_W-1:2*ID_W];

    assign lim      = (node_count_reg < MAX_CAP) ? node_count_reg : MAX_CAP;
    assign root_cur = cmd.phase_b ? root_b_reg : root_a_reg;
    assign joined   = !bad_reg && (root_a_reg != root_b_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_INPUT:   rd_addr = in_a[IDX_W-1:0];
            RD_DATA:    rd_addr = rd_data_reg;
            RD_START_A: rd_addr = a_reg;
            RD_START_B: rd_addr = b_reg;
            default:    rd_addr = rd_data_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = clr_reg;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.comp_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_reg;
            wr_data = root_cur;
        end
        else if (cmd.link && joined)
        begin
            wr_en   = 1'b1;
            wr_addr = root_a_reg;
            wr_data = root_b_reg;
        end
    end

    always_comb
    begin
        weight_next = weight_total_reg;
        edge_next   = edge_total_reg;
        if (joined)
        begin
            weight_next = weight_total_reg + {{(TOT_W-WGT_W){1'b0}}, w_reg};
            edge_next   = edge_total_reg + CNT_W'(1);
        end
        spanning = (lim != '0) && ({1'b0, edge_next} == (lim - NC_W'(1)));
    end

    always_comb
    begin
        sts.bad_in   = ({1'b0, in_a} >= lim) || ({1'b0, in_b} >= lim);
        sts.is_root  = (rd_data_reg == cur_reg);
        sts.comp_end = (rd_data_reg == root_cur);
        sts.clr_last = (clr_reg == IDX_W'(DEPTH - 1));
        sts.out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= parent_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= in_a[IDX_W-1:0];
            b_reg <= in_b[IDX_W-1:0];
            w_reg <= in_w;
            bad_reg <= sts.bad_in;
        end
        if (cmd.rd_en)
        begin
            cur_reg <= rd_addr;
        end
        if (cmd.root_ld)
        begin
            if (cmd.phase_b)
            begin
                root_b_reg <= cur_reg;
            end
            else
            begin
                root_a_reg <= cur_reg;
            end
        end
        if (cmd.link)
        begin
            out_data_reg <= {{M_PAD_W{1'b0}}, bad_reg, spanning, edge_next,
                             weight_next, joined};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg          <= '0;
            node_count_reg   <= NC_W'(NC_RESET);
            weight_total_reg <= '0;
            edge_total_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.link)
            begin
                weight_total_reg <= weight_next;
                edge_total_reg   <= edge_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
